[hdl/ngc_pkg.sv]
// Shared constants, codes and fixed-point helpers for the gridding convolution block.
`timescale 1ns / 1ps
package ngc_pkg;

   localparam int AXES       = 4;
   localparam int MAX_TAPS   = 16;
   localparam int GRID_WORDS = 4096;
   localparam int AXIS_MAX   = 8;

   localparam int AXIS_W  = $clog2(AXES);
   localparam int TAP_W   = $clog2(MAX_TAPS);
   localparam int GADDR_W = $clog2(GRID_WORDS);
   localparam int COORD_W = $clog2(AXIS_MAX);
   localparam int SIZE_W  = 4;
   localparam int WT_DEPTH = AXES * MAX_TAPS;
   localparam int WT_AW    = $clog2(WT_DEPTH);

   localparam int VAL_W  = 24;
   localparam int WGT_W  = 18;
   localparam int OUT_W  = 32;
   localparam int PHI_W  = 26;
   localparam int OPB_W  = 25;
   localparam int PROD_W = PHI_W + OPB_W;
   localparam int TERM_W = PROD_W - 15;
   localparam int ACC_W  = 52;

   localparam logic [2:0] MODE_WRITE   = 3'd0;
   localparam logic [2:0] MODE_READ    = 3'd1;
   localparam logic [2:0] MODE_CLEAR   = 3'd2;
   localparam logic [2:0] MODE_START   = 3'd3;
   localparam logic [2:0] MODE_WEIGHT  = 3'd4;
   localparam logic [2:0] MODE_FORWARD = 3'd5;
   localparam logic [2:0] MODE_ADJOINT = 3'd6;

   localparam logic [2:0] REG_SIZE0      = 3'd0;
   localparam logic [2:0] REG_SIZE1      = 3'd1;
   localparam logic [2:0] REG_SIZE2      = 3'd2;
   localparam logic [2:0] REG_SIZE3      = 3'd3;
   localparam logic [2:0] REG_HALF_WIDTH = 3'd4;

   // Shift right by 15 with rounding half up.
   function automatic logic signed [TERM_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = p + PROD_W'(16384);
      return s[PROD_W-1:15];
   endfunction

   function automatic logic signed [VAL_W-1:0] sat24(input logic signed [TERM_W:0] v);
      if (v > (TERM_W+1)'(8388607)) return 24'sh7fffff;
      if (v < -(TERM_W+1)'(8388608)) return 24'sh800000;
      return v[VAL_W-1:0];
   endfunction

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(64'sd2147483647)) return 32'sh7fffffff;
      if (v < -ACC_W'(64'sd2147483648)) return 32'sh80000000;
      return v[OUT_W-1:0];
   endfunction

endpackage

[hdl/nufft_grid_convolution.sv]
// Top level of the gridding convolution engine: sequencer, shared multiplier and memories.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; busy then stays high until the
// request is finished. Grid writes, start and weight writes take effect at the accepting
// edge and leave busy low. A grid read keeps busy high through states RD1 and RD2 and shows
// its word on the result ports in the cycle right after RD2. A grid clear sweeps every grid
// word, one per cycle. A node runs one shared multiplier through every window point in
// turn: for each point, states WADDR, WMUL and WRND form the weight product on each axis,
// then GADDR, MRE, MIM and ACC handle the grid word; INIT wraps the starts and DONE
// finishes. Taps per axis are 2 * half_width + 2. A start that is not below its size is
// reduced in INIT by repeated subtraction. Each result is shown for exactly one cycle with
// rsp_valid high and cannot be held off. The configuration port is always ready and must
// be written only while idle.
module nufft_grid_convolution import ngc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_mode,
   input  logic [GADDR_W-1:0]       req_grid_index,
   input  logic [AXIS_W-1:0]        req_axis,
   input  logic [TAP_W-1:0]         req_tap,
   input  logic signed [WGT_W-1:0]  req_weight,
   input  logic [COORD_W-1:0]       req_start_req,
   input  logic signed [VAL_W-1:0]  req_value_re,
   input  logic signed [VAL_W-1:0]  req_value_im,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_result_re,
   output logic signed [OUT_W-1:0]  rsp_result_im,
   output logic                     rsp_from_node,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [SIZE_W-1:0]        csr_data
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_RD1   = 13'b0000000000010,
      ST_RD2   = 13'b0000000000100,
      ST_CLEAR = 13'b0000000001000,
      ST_INIT  = 13'b0000000010000,
      ST_WADDR = 13'b0000000100000,
      ST_WMUL  = 13'b0000001000000,
      ST_WRND  = 13'b0000010000000,
      ST_GADDR = 13'b0000100000000,
      ST_MRE   = 13'b0001000000000,
      ST_MIM   = 13'b0010000000000,
      ST_ACC   = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]  size_ff [AXES];
   logic [2:0]         hw_ff;
   logic [COORD_W-1:0] start_ff [AXES];
   logic [WT_DEPTH-1:0] wv_ff, wv_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic               rsp_node_ff, rsp_node_in;

   logic               fwd_ff, fwd_in;
   logic signed [VAL_W-1:0] vre_ff, vre_in, vim_ff, vim_in;
   logic [AXIS_W-1:0]  ax_ff, ax_in;
   logic [TAP_W-1:0]   lj_ff [AXES];
   logic [TAP_W-1:0]   lj_in [AXES];
   logic [COORD_W:0]   coord_ff [AXES];
   logic [COORD_W:0]   coord_in [AXES];
   logic [COORD_W:0]   init_ff [AXES];
   logic [COORD_W:0]   init_in [AXES];
   logic [GADDR_W-1:0] addr_ff, addr_in;
   logic signed [PHI_W-1:0]  phi_ff, phi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [TERM_W-1:0] tre_ff, tre_in;
   logic signed [VAL_W-1:0]  gre_ff, gre_in, gim_ff, gim_in;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic               wvld_ff, wvld_in;

   logic [SIZE_W-1:0]  eff_sz [AXES];
   logic [4:0]         taps_m1;
   logic               accept;

   logic                   g_we;
   logic [GADDR_W-1:0]     g_waddr;
   logic [2*VAL_W-1:0]     g_wdata;
   logic [2*VAL_W-1:0]     g_rdata;
   logic                   w_we;
   logic [WT_AW-1:0]       w_waddr;
   logic [WT_AW-1:0]       w_raddr;
   logic [WGT_W-1:0]       w_rdata;

   logic signed [OPB_W-1:0]  opb;
   logic signed [PROD_W-1:0] mul_out;
   logic signed [TERM_W-1:0] rnd;
   logic signed [TERM_W:0]   sum_re, sum_im;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign taps_m1   = {1'b0, hw_ff, 1'b0} + 5'd1;

   always_comb begin
      for (int t = 0; t < AXES; t++) begin
         if (size_ff[t] == '0) begin
            eff_sz[t] = SIZE_W'(1);
         end else if (size_ff[t] > SIZE_W'(AXIS_MAX)) begin
            eff_sz[t] = SIZE_W'(AXIS_MAX);
         end else begin
            eff_sz[t] = size_ff[t];
         end
      end
   end

   ngc_ram #(.WIDTH(2*VAL_W), .DEPTH(GRID_WORDS)) u_grid (
      .clock   (clock),
      .wr_en   (g_we),
      .wr_addr (g_waddr),
      .wr_data (g_wdata),
      .rd_addr (addr_ff),
      .rd_data (g_rdata)
   );

   ngc_ram #(.WIDTH(WGT_W), .DEPTH(WT_DEPTH)) u_weight (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_weight),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   assign w_we    = accept && (req_mode == MODE_WEIGHT);
   assign w_waddr = {req_axis, req_tap};
   assign w_raddr = {ax_ff, lj_ff[ax_ff]};

   // The single shared multiplier: phi times a weight, a grid part or the node value.
   always_comb begin
      opb = '0;
      case (state_ff)
         ST_WMUL: opb = wvld_ff ? OPB_W'($signed(w_rdata)) : '0;
         ST_MRE:  opb = fwd_ff ? OPB_W'($signed(g_rdata[2*VAL_W-1:VAL_W]))
                               : OPB_W'(vre_ff);
         ST_MIM:  opb = fwd_ff ? OPB_W'(gim_ff) : OPB_W'(vim_ff);
         default: opb = '0;
      endcase
      mul_out = phi_ff * opb;
   end

   assign rnd    = round_q15(prod_ff);
   assign sum_re = (TERM_W+1)'(gre_ff) + (TERM_W+1)'(tre_ff);
   assign sum_im = (TERM_W+1)'(gim_ff) + (TERM_W+1)'(rnd);

   always_comb begin
      g_we    = 1'b0;
      g_waddr = addr_ff;
      g_wdata = '0;
      case (state_ff)
         ST_IDLE: begin
            g_we    = accept && (req_mode == MODE_WRITE);
            g_waddr = req_grid_index;
            g_wdata = {req_value_re, req_value_im};
         end
         ST_CLEAR: g_we = 1'b1;
         ST_ACC: begin
            g_we    = !fwd_ff;
            g_wdata = {sat24(sum_re), sat24(sum_im)};
         end
         default: g_we = 1'b0;
      endcase
   end

   always_comb begin
      logic carry;
      state_in     = state_ff;
      wv_in        = wv_ff;
      rsp_valid_in = 1'b0;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_node_in  = rsp_node_ff;
      fwd_in       = fwd_ff;
      vre_in       = vre_ff;
      vim_in       = vim_ff;
      ax_in        = ax_ff;
      lj_in        = lj_ff;
      coord_in     = coord_ff;
      init_in      = init_ff;
      addr_in      = addr_ff;
      phi_in       = phi_ff;
      prod_in      = prod_ff;
      tre_in       = tre_ff;
      gre_in       = gre_ff;
      gim_in       = gim_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      wvld_in      = wvld_ff;
      carry        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_READ: begin
                     addr_in  = req_grid_index;
                     state_in = ST_RD1;
                  end
                  MODE_CLEAR: begin
                     addr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  MODE_WEIGHT: wv_in[{req_axis, req_tap}] = 1'b1;
                  MODE_FORWARD, MODE_ADJOINT: begin
                     fwd_in    = (req_mode == MODE_FORWARD);
                     vre_in    = req_value_re;
                     vim_in    = req_value_im;
                     acc_re_in = '0;
                     acc_im_in = '0;
                     for (int t = 0; t < AXES; t++) begin
                        lj_in[t]    = '0;
                        coord_in[t] = {1'b0, start_ff[t]};
                     end
                     state_in = ST_INIT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD1: state_in = ST_RD2;
         ST_RD2: begin
            rsp_valid_in = 1'b1;
            rsp_re_in    = OUT_W'($signed(g_rdata[2*VAL_W-1:VAL_W]));
            rsp_im_in    = OUT_W'($signed(g_rdata[VAL_W-1:0]));
            rsp_node_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_CLEAR: begin
            addr_in = addr_ff + GADDR_W'(1);
            if (addr_ff == GADDR_W'(GRID_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            // Reduce each start modulo its axis size by repeated subtraction.
            carry = 1'b0;
            for (int t = 0; t < AXES; t++) begin
               if (coord_ff[t] >= eff_sz[t]) begin
                  coord_in[t] = coord_ff[t] - eff_sz[t];
                  carry       = 1'b1;
               end
            end
            if (!carry) begin
               init_in  = coord_ff;
               ax_in    = '0;
               phi_in   = PHI_W'(32768);
               addr_in  = '0;
               state_in = ST_WADDR;
            end
         end
         ST_WADDR: begin
            wvld_in  = wv_ff[{ax_ff, lj_ff[ax_ff]}];
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            prod_in  = mul_out;
            state_in = ST_WRND;
         end
         ST_WRND: begin
            phi_in  = rnd[PHI_W-1:0];
            addr_in = GADDR_W'(addr_ff * eff_sz[ax_ff]) + GADDR_W'(coord_ff[ax_ff]);
            if (ax_ff == AXIS_W'(AXES - 1)) begin
               state_in = ST_GADDR;
            end else begin
               ax_in    = ax_ff + AXIS_W'(1);
               state_in = ST_WADDR;
            end
         end
         ST_GADDR: state_in = ST_MRE;
         ST_MRE: begin
            gre_in   = $signed(g_rdata[2*VAL_W-1:VAL_W]);
            gim_in   = $signed(g_rdata[VAL_W-1:0]);
            prod_in  = mul_out;
            state_in = ST_MIM;
         end
         ST_MIM: begin
            tre_in   = rnd;
            prod_in  = mul_out;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (fwd_ff) begin
               acc_re_in = acc_re_ff + ACC_W'(tre_ff);
               acc_im_in = acc_im_ff + ACC_W'(rnd);
            end
            // Step the tap counters, last axis fastest.
            carry = 1'b1;
            for (int t = AXES - 1; t >= 0; t--) begin
               if (carry) begin
                  if ({1'b0, lj_ff[t]} == taps_m1) begin
                     lj_in[t]    = '0;
                     coord_in[t] = init_ff[t];
                  end else begin
                     lj_in[t]    = lj_ff[t] + TAP_W'(1);
                     coord_in[t] = (coord_ff[t] + (COORD_W+1)'(1) == eff_sz[t]) ? '0
                                 : coord_ff[t] + (COORD_W+1)'(1);
                     carry       = 1'b0;
                  end
               end
            end
            ax_in   = '0;
            phi_in  = PHI_W'(32768);
            addr_in = '0;
            state_in = carry ? ST_DONE : ST_WADDR;
         end
         ST_DONE: begin
            rsp_valid_in = fwd_ff;
            rsp_re_in    = sat32(acc_re_ff);
            rsp_im_in    = sat32(acc_im_ff);
            rsp_node_in  = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wv_ff        <= '0;
         hw_ff        <= 3'd1;
         for (int t = 0; t < AXES; t++) begin
            size_ff[t]  <= SIZE_W'(8);
            start_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wv_ff        <= wv_in;
         if (accept && (req_mode == MODE_START)) begin
            start_ff[req_axis] <= req_start_req;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SIZE0:      size_ff[0] <= csr_data;
               REG_SIZE1:      size_ff[1] <= csr_data;
               REG_SIZE2:      size_ff[2] <= csr_data;
               REG_SIZE3:      size_ff[3] <= csr_data;
               REG_HALF_WIDTH: hw_ff      <= csr_data[2:0];
               default:        hw_ff      <= hw_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_node_ff <= rsp_node_in;
      fwd_ff      <= fwd_in;
      vre_ff      <= vre_in;
      vim_ff      <= vim_in;
      ax_ff       <= ax_in;
      lj_ff       <= lj_in;
      coord_ff    <= coord_in;
      init_ff     <= init_in;
      addr_ff     <= addr_in;
      phi_ff      <= phi_in;
      prod_ff     <= prod_in;
      tre_ff      <= tre_in;
      gre_ff      <= gre_in;
      gim_ff      <= gim_in;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
      wvld_ff     <= wvld_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_re = rsp_re_ff;
   assign rsp_result_im = rsp_im_ff;
   assign rsp_from_node = rsp_node_ff;

endmodule

[hdl/ngc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ngc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ngc_checker.sv]
// Port-level checks for the gridding convolution block, bound to its top level.
`timescale 1ns / 1ps
module ngc_checker import ngc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [2:0] req_mode,
   input logic       rsp_valid
);

   // A result is a single-cycle strobe.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe lasted two cycles");

   // A result only appears once the block has come back to idle.
   a_idle_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while busy");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_READ) |=> busy)
      else $error("grid read request did not make the block busy");

   a_write_quick: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_mode == MODE_WRITE) |=> !busy && !rsp_valid)
      else $error("grid write request stalled or gave a result");

endmodule

bind nufft_grid_convolution ngc_checker u_ngc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_mode  (req_mode),
   .rsp_valid (rsp_valid)
);
